// ===== rtl/ldpb_pkg.sv =====
// ----------------------------------------------------------------------------
// ldpb_pkg: shared types and constants of the scanner packet deframer
// Packet layout, angle arithmetic constants, queue record and back-end states.
// ----------------------------------------------------------------------------
package ldpb_pkg;

    // Packet framing
    localparam int PACKET_BYTES = 47;
    localparam int POINTS       = 12;
    localparam int ANGLE_BINS   = 360;
    localparam int CNT_W        = 6;
    localparam int PIDX_W       = 4;

    localparam logic [7:0] HDR0 = 8'h54;
    localparam logic [7:0] HDR1 = 8'h2C;

    localparam logic [CNT_W-1:0] CNT_HDR0  = CNT_W'(0);
    localparam logic [CNT_W-1:0] CNT_HDR1  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_BODY  = CNT_W'(2);
    localparam logic [CNT_W-1:0] START_LO  = CNT_W'(4);
    localparam logic [CNT_W-1:0] START_HI  = CNT_W'(5);
    localparam logic [CNT_W-1:0] PT_FIRST  = CNT_W'(6);
    localparam logic [CNT_W-1:0] PT_LAST   = CNT_W'(6 + 3 * POINTS - 1);
    localparam logic [CNT_W-1:0] END_LO    = CNT_W'(6 + 3 * POINTS);
    localparam logic [CNT_W-1:0] END_HI    = CNT_W'(6 + 3 * POINTS + 1);
    localparam logic [CNT_W-1:0] LAST_BYTE = CNT_W'(PACKET_BYTES - 1);

    localparam logic [PIDX_W-1:0] LAST_PT = PIDX_W'(POINTS - 1);

    // Angle arithmetic in units of 1/(100*SEG) degree
    localparam int SEG         = POINTS - 1;
    localparam int CIRCLE      = ANGLE_BINS * 100;
    localparam int FULL        = CIRCLE * SEG;
    localparam int HALF        = 50 * SEG;
    localparam int BIN_DIV     = 100 * SEG;
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP       = (2**RECIP_SHIFT + BIN_DIV - 1) / BIN_DIV;
    localparam int ACC_W       = 32;
    localparam int REM_W       = 19;
    localparam int RECIP_W     = 20;
    localparam int PROD_W      = REM_W + RECIP_W;
    localparam int BIN_W       = 9;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [7:0]  inten;
        logic [15:0] range_mm;
    } t_point;

    typedef struct packed {
        t_point [POINTS-1:0] pts;
        logic [15:0]         sweep_to;
        logic [15:0]         sweep_from;
        logic                scan;
    } t_packet;

    typedef struct packed {
        logic              last;
        logic              scan;
        logic              pvalid;
        logic [7:0]        inten;
        logic [15:0]       range_mm;
        logic [BIN_W-1:0]  bin;
    } t_result;

    typedef enum logic [1:0] {
        PH_LO,
        PH_HI,
        PH_INT
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_OUT
    } t_back_state;

endpackage

// ===== rtl/lidar_packet_deframe_and_bin.sv =====
// ----------------------------------------------------------------------------
// lidar_packet_deframe_and_bin: scanner packet deframer and angle binner
// Byte stream in, twelve binned points out per 47-byte packet.
// ----------------------------------------------------------------------------
// The input side takes one scanner byte per transfer and is ready every
// cycle except on the final byte of a packet while two finished packets
// are still queued. The front hunts for the header pair 0x54 0x2C,
// collects the packet and pushes one record per packet into a two-entry
// queue; the CRC byte is not checked. The back walks the twelve points of
// the head record after a packet-setup state: each point takes a
// reciprocal multiply that rounds the mirrored angle to a bin, then a load
// of the output register, which waits only on sink stalls; nothing else
// holds the back up while it walks a packet. The interpolated angle is
// kept below a full circle with one compare and subtract per point. The
// output register holds a point until the sink takes it, while the front
// keeps collecting. Each point carries a mirrored, rounded one-degree bin
// (0..359), the distance, the intensity, a valid flag (distance above
// min_distance_mm, reset 150), a new-revolution flag on all points of a
// packet whose start angle dropped below the previous one, and tlast on
// the twelfth point. Write min_distance_mm only while idle.
// ----------------------------------------------------------------------------
module lidar_packet_deframe_and_bin (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,     // min_distance_mm
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,    // [8:0] bin_index, [24:9] distance_mm,
                                         // [32:25] intensity, [39:33] zero
    output logic [1:0]  m_axis_tuser,    // [0] point_valid, [1] scan_start
    output logic        m_axis_tlast     // last_point
);

    logic              w_push;
    logic              w_full;
    logic              w_pop;
    logic              w_q_valid;
    ldpb_pkg::t_packet w_pkt;
    ldpb_pkg::t_packet w_head;
    ldpb_pkg::t_result w_res;

    // Hunt, collect, push one record per packet
    ldpb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .o_push  (w_push),
        .o_pkt   (w_pkt),
        .i_full  (w_full)
    );

    // Hold up to two finished packets
    ldpb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_pkt),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_head  (w_head)
    );

    // Compute and emit points of the head packet
    ldpb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (w_q_valid),
        .i_q_head    (w_head),
        .o_q_pop     (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_res       (w_res)
    );

    // Pack point fields, lowest field first, zero padded to whole bytes
    assign m_axis_tdata = 40'({w_res.inten, w_res.range_mm, w_res.bin});
    assign m_axis_tuser = {w_res.scan, w_res.pvalid};
    assign m_axis_tlast = w_res.last;

endmodule

// ===== rtl/ldpb_front.sv =====
// ----------------------------------------------------------------------------
// ldpb_front: header hunt and packet collection
// Finds the header pair, captures angles and point records, pushes one
// packet record per complete packet and tracks the revolution start.
// ----------------------------------------------------------------------------
module ldpb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    output logic              o_push,
    output ldpb_pkg::t_packet o_pkt,
    input  logic              i_full
);

    logic [ldpb_pkg::CNT_W-1:0]  r_count;
    logic [ldpb_pkg::PIDX_W-1:0] r_pidx;
    ldpb_pkg::t_phase            r_phase;
    logic [15:0]                 r_start;
    logic [15:0]                 r_end;
    logic [15:0]                 r_prev_start;
    logic                        r_prev_known;
    ldpb_pkg::t_point [ldpb_pkg::POINTS-1:0] r_pts;

    logic w_acc;
    logic w_done;
    logic w_in_pts;

    // Stall only the final byte while the queue is full
    assign o_ready  = !((r_count == ldpb_pkg::LAST_BYTE) && i_full);
    assign w_acc    = i_valid && o_ready;
    assign w_done   = w_acc && (r_count == ldpb_pkg::LAST_BYTE);
    assign w_in_pts = r_count inside {[ldpb_pkg::PT_FIRST : ldpb_pkg::PT_LAST]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= ldpb_pkg::CNT_HDR0;
            r_pidx       <= '0;
            r_phase      <= ldpb_pkg::PH_LO;
            r_prev_start <= '0;
            r_prev_known <= 1'b0;
        end else if (w_acc) begin
            case (r_count)
                ldpb_pkg::CNT_HDR0: begin
                    if (i_byte == ldpb_pkg::HDR0) begin
                        r_count <= ldpb_pkg::CNT_HDR1;
                    end
                end
                ldpb_pkg::CNT_HDR1: begin
                    if (i_byte == ldpb_pkg::HDR1) begin
                        r_count <= ldpb_pkg::CNT_BODY;
                        r_pidx  <= '0;
                        r_phase <= ldpb_pkg::PH_LO;
                    end else if (i_byte == ldpb_pkg::HDR0) begin
                        r_count <= ldpb_pkg::CNT_HDR1;
                    end else begin
                        r_count <= ldpb_pkg::CNT_HDR0;
                    end
                end
                default: begin
                    if (r_count == ldpb_pkg::LAST_BYTE) begin
                        r_count      <= ldpb_pkg::CNT_HDR0;
                        r_prev_start <= r_start;
                        r_prev_known <= 1'b1;
                    end else begin
                        r_count <= r_count + ldpb_pkg::CNT_W'(1);
                    end
                    if (w_in_pts) begin
                        case (r_phase)
                            ldpb_pkg::PH_LO:  r_phase <= ldpb_pkg::PH_HI;
                            ldpb_pkg::PH_HI:  r_phase <= ldpb_pkg::PH_INT;
                            default: begin
                                r_phase <= ldpb_pkg::PH_LO;
                                r_pidx  <= r_pidx + ldpb_pkg::PIDX_W'(1);
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            if (r_count == ldpb_pkg::START_LO) r_start[7:0]  <= i_byte;
            if (r_count == ldpb_pkg::START_HI) r_start[15:8] <= i_byte;
            if (r_count == ldpb_pkg::END_LO)   r_end[7:0]    <= i_byte;
            if (r_count == ldpb_pkg::END_HI)   r_end[15:8]   <= i_byte;
            if (w_in_pts) begin
                case (r_phase)
                    ldpb_pkg::PH_LO:  r_pts[r_pidx].range_mm[7:0]  <= i_byte;
                    ldpb_pkg::PH_HI:  r_pts[r_pidx].range_mm[15:8] <= i_byte;
                    default:          r_pts[r_pidx].inten          <= i_byte;
                endcase
            end
        end
    end

    assign o_push = w_done;

    always_comb begin
        o_pkt.pts        = r_pts;
        o_pkt.sweep_to   = r_end;
        o_pkt.sweep_from = r_start;
        o_pkt.scan       = r_prev_known && (r_start < r_prev_start);
    end

endmodule

// ===== rtl/ldpb_queue.sv =====
// ----------------------------------------------------------------------------
// ldpb_queue: two-entry packet record queue
// Decouples packet collection from point computation.
// ----------------------------------------------------------------------------
module ldpb_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ldpb_pkg::t_packet i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output ldpb_pkg::t_packet o_head
);

    ldpb_pkg::t_packet r_mem [ldpb_pkg::QUEUE_DEPTH];
    logic [ldpb_pkg::QPTR_W-1:0] r_wr;
    logic [ldpb_pkg::QPTR_W-1:0] r_rd;
    logic [ldpb_pkg::QCNT_W-1:0] r_cnt;
    logic [ldpb_pkg::QCNT_W-1:0] n_cnt;

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + ldpb_pkg::QCNT_W'(1);
            2'b01:   n_cnt = r_cnt - ldpb_pkg::QCNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + ldpb_pkg::QPTR_W'(1);
            if (i_pop)  r_rd <= r_rd + ldpb_pkg::QPTR_W'(1);
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == ldpb_pkg::QCNT_W'(ldpb_pkg::QUEUE_DEPTH));

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ldpb_pkg::QCNT_W'(ldpb_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr == r_rd))
        else $error("pointers disagree on empty queue");
`endif

endmodule

// ===== rtl/ldpb_back.sv =====
// ----------------------------------------------------------------------------
// ldpb_back: point sequencer and angle binner
// Walks the twelve points of the head packet, keeps the interpolated angle
// below a full circle with one compare and subtract per step and rounds it to
// a bin with a reciprocal multiply.
// ----------------------------------------------------------------------------
module ldpb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_q_valid,
    input  ldpb_pkg::t_packet i_q_head,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output ldpb_pkg::t_result o_res
);

    ldpb_pkg::t_back_state r_state;
    ldpb_pkg::t_back_state n_state;

    logic [ldpb_pkg::PIDX_W-1:0] r_idx;
    logic [ldpb_pkg::ACC_W-1:0]  r_t;
    logic [ldpb_pkg::ACC_W-1:0]  r_span;
    logic [ldpb_pkg::PROD_W-1:0] r_prod;
    logic [15:0]                 r_min_dist;
    logic                        r_o_valid;
    ldpb_pkg::t_result           r_res;

    logic                         w_free;
    logic                         w_load;
    logic [ldpb_pkg::ACC_W-1:0]   w_t0;
    logic [ldpb_pkg::ACC_W-1:0]   w_t0_mod;
    logic [ldpb_pkg::ACC_W-1:0]   w_span;
    logic [ldpb_pkg::ACC_W-1:0]   w_t_sum;
    logic [ldpb_pkg::ACC_W-1:0]   w_t_next;
    logic [ldpb_pkg::REM_W-1:0]   w_t_lo;
    logic [ldpb_pkg::REM_W-1:0]   w_x;
    logic [ldpb_pkg::BIN_W-1:0]   w_bin;
    ldpb_pkg::t_point             w_pt;

    assign w_free   = !r_o_valid || i_ready;
    assign w_t0     = ldpb_pkg::ACC_W'(i_q_head.sweep_from) *
                      ldpb_pkg::ACC_W'(ldpb_pkg::SEG);
    // start*SEG stays below two full circles, one subtract reduces it
    assign w_t0_mod = (w_t0 >= ldpb_pkg::ACC_W'(ldpb_pkg::FULL))
                    ? w_t0 - ldpb_pkg::ACC_W'(ldpb_pkg::FULL) : w_t0;
    assign w_span   = (i_q_head.sweep_to >= i_q_head.sweep_from)
                    ? ldpb_pkg::ACC_W'(i_q_head.sweep_to) -
                      ldpb_pkg::ACC_W'(i_q_head.sweep_from)
                    : ldpb_pkg::ACC_W'(i_q_head.sweep_to) +
                      ldpb_pkg::ACC_W'(ldpb_pkg::CIRCLE) -
                      ldpb_pkg::ACC_W'(i_q_head.sweep_from);
    // span is below a full circle, so one subtract keeps the angle reduced
    assign w_t_sum  = r_t + r_span;
    assign w_t_next = (w_t_sum >= ldpb_pkg::ACC_W'(ldpb_pkg::FULL))
                    ? w_t_sum - ldpb_pkg::ACC_W'(ldpb_pkg::FULL) : w_t_sum;
    assign w_t_lo   = r_t[ldpb_pkg::REM_W-1:0];
    // mirror and add the rounding half in one subtract
    assign w_x      = (w_t_lo == '0) ? ldpb_pkg::REM_W'(ldpb_pkg::HALF)
                    : ldpb_pkg::REM_W'(ldpb_pkg::FULL + ldpb_pkg::HALF) - w_t_lo;
    assign w_bin    = r_prod[ldpb_pkg::PROD_W-1:ldpb_pkg::RECIP_SHIFT];
    assign w_pt     = i_q_head.pts[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ldpb_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            ldpb_pkg::BK_IDLE: begin
                if (i_q_valid) n_state = ldpb_pkg::BK_MUL;
            end
            ldpb_pkg::BK_MUL: begin
                n_state = ldpb_pkg::BK_OUT;
            end
            ldpb_pkg::BK_OUT: begin
                if (w_free) begin
                    w_load = 1'b1;
                    if (r_idx == ldpb_pkg::LAST_PT) begin
                        o_q_pop = 1'b1;
                        n_state = ldpb_pkg::BK_IDLE;
                    end else begin
                        n_state = ldpb_pkg::BK_MUL;
                    end
                end
            end
            default: n_state = ldpb_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_o_valid  <= 1'b0;
            r_min_dist <= 16'd150;
        end else begin
            if (i_cfg_we) r_min_dist <= i_cfg_wdata;
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ldpb_pkg::BK_IDLE: begin
                    r_idx <= '0;
                end
                ldpb_pkg::BK_OUT: begin
                    if (w_load && (r_idx != ldpb_pkg::LAST_PT)) begin
                        r_idx <= r_idx + ldpb_pkg::PIDX_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ldpb_pkg::BK_IDLE: begin
                r_t    <= w_t0_mod;
                r_span <= w_span;
            end
            ldpb_pkg::BK_MUL: begin
                r_prod <= ldpb_pkg::PROD_W'(w_x) *
                          ldpb_pkg::PROD_W'(ldpb_pkg::RECIP);
            end
            ldpb_pkg::BK_OUT: begin
                if (w_load && (r_idx != ldpb_pkg::LAST_PT)) begin
                    r_t <= w_t_next;
                end
            end
            default: begin
            end
        endcase
        if (w_load) begin
            r_res.bin      <= (w_bin >= ldpb_pkg::BIN_W'(ldpb_pkg::ANGLE_BINS)) ? '0 : w_bin;
            r_res.range_mm <= w_pt.range_mm;
            r_res.inten    <= w_pt.inten;
            r_res.pvalid   <= (w_pt.range_mm > r_min_dist);
            r_res.scan     <= i_q_head.scan;
            r_res.last     <= (r_idx == ldpb_pkg::LAST_PT);
        end
    end

    assign o_valid = r_o_valid;
    assign o_res   = r_res;

`ifndef SYNTHESIS
    a_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid)
        else $error("packet released while queue empty");
    a_pop_gives_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_o_valid && r_res.last))
        else $error("packet released without its last point");
    a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ldpb_pkg::BK_MUL) |-> (r_t < ldpb_pkg::ACC_W'(ldpb_pkg::FULL)))
        else $error("angle not reduced below full circle");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= ldpb_pkg::LAST_PT)
        else $error("point index out of range");
`endif

endmodule

// ===== tb/sv/ldpb_point_checker.sv =====
// ----------------------------------------------------------------------------
// ldpb_point_checker: point stream checker for the scanner packet deframer
// Watches the byte and point channels and the threshold writes, works out the
// twelve points of every complete packet, and compares them in order.
// ----------------------------------------------------------------------------
module ldpb_point_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_pt_valid,
    input  logic        i_pt_ready,
    input  logic [39:0] i_pt_data,
    input  logic [1:0]  i_pt_user,
    input  logic        i_pt_last,
    output int          o_fail_count,
    output int          o_points_pending
);
    import ldpb_pkg::*;

    localparam logic [15:0] MIN_DIST_RESET = 16'd150;

    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic [15:0]      range_mm;
        logic [7:0]       level;
        logic             pvalid;
        logic             scan;
        logic             last;
    } t_point_due;

    logic [7:0]       frame_bytes [PACKET_BYTES];
    logic [CNT_W-1:0] frame_pos;
    logic [15:0]      prev_start;
    logic             prev_start_seen;
    logic [15:0]      min_dist;
    t_point_due       points_due [$];

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : track
        logic [15:0]      start_ang;
        logic [15:0]      stop_ang;
        logic [15:0]      range_mm;
        logic             scan;
        int unsigned      start_units;
        int unsigned      span;
        int unsigned      pos;
        int unsigned      mirrored;
        int unsigned      bin;
        logic [CNT_W-1:0] ofs;
        t_point_due       pt;
        t_point_due       want;

        if (!i_rst_n) begin
            frame_pos       = CNT_HDR0;
            prev_start      = '0;
            prev_start_seen = 1'b0;
            min_dist        = MIN_DIST_RESET;
            o_fail_count    = 0;
            points_due.delete();
        end else begin
            if (i_cfg_we) begin
                min_dist = i_cfg_wdata;
            end

            if (i_in_valid && i_in_ready) begin
                case (frame_pos)
                    CNT_HDR0: begin
                        if (i_in_byte == HDR0) begin
                            frame_pos = CNT_HDR1;
                        end
                    end
                    CNT_HDR1: begin
                        // a repeated first header byte keeps the hunt alive
                        if (i_in_byte == HDR1) begin
                            frame_pos = CNT_BODY;
                        end else if (i_in_byte != HDR0) begin
                            frame_pos = CNT_HDR0;
                        end
                    end
                    default: begin
                        frame_bytes[frame_pos] = i_in_byte;
                        frame_pos = frame_pos + CNT_W'(1);
                        if (frame_pos == CNT_W'(PACKET_BYTES)) begin
                            frame_pos = CNT_HDR0;
                            start_ang = {frame_bytes[START_HI], frame_bytes[START_LO]};
                            stop_ang  = {frame_bytes[END_HI], frame_bytes[END_LO]};
                            scan = prev_start_seen && (start_ang < prev_start);
                            prev_start      = start_ang;
                            prev_start_seen = 1'b1;

                            // start and span in 1/100 degree, span wraps once past the circle
                            start_units = start_ang;
                            span = (stop_ang >= start_ang) ?
                                   int'(stop_ang) - start_units :
                                   int'(stop_ang) + CIRCLE - start_units;
                            for (int i = 0; i < POINTS; i++) begin
                                pos      = (start_units * SEG + span * i) % FULL;
                                mirrored = (pos == 0) ? 0 : FULL - pos;
                                bin      = (mirrored + HALF) / BIN_DIV;
                                if (bin >= ANGLE_BINS) begin
                                    bin = 0;
                                end
                                ofs         = CNT_W'(PT_FIRST + 3 * i);
                                range_mm    = {frame_bytes[ofs + CNT_W'(1)], frame_bytes[ofs]};
                                pt.bin      = BIN_W'(bin);
                                pt.range_mm = range_mm;
                                pt.level    = frame_bytes[ofs + CNT_W'(2)];
                                pt.pvalid   = range_mm > min_dist;
                                pt.scan     = scan;
                                pt.last     = (i == POINTS - 1);
                                points_due.push_back(pt);
                            end
                        end
                    end
                endcase
            end

            if (i_pt_valid && i_pt_ready) begin
                if (points_due.size() == 0) begin
                    $error("unexpected point: bin %0d distance %0d",
                           i_pt_data[8:0], i_pt_data[24:9]);
                    o_fail_count++;
                end else begin
                    want = points_due.pop_front();
                    check_field("bin_index", 32'(want.bin), 32'(i_pt_data[8:0]));
                    check_field("distance_mm", 32'(want.range_mm), 32'(i_pt_data[24:9]));
                    check_field("intensity", 32'(want.level), 32'(i_pt_data[32:25]));
                    check_field("tdata padding", 0, 32'(i_pt_data[39:33]));
                    check_field("point_valid", 32'(want.pvalid), 32'(i_pt_user[0]));
                    check_field("scan_start", 32'(want.scan), 32'(i_pt_user[1]));
                    check_field("last_point", 32'(want.last), 32'(i_pt_last));
                end
            end
        end
        o_points_pending = points_due.size();
    end

endmodule

// ===== tb/sv/lidar_packet_deframe_and_bin_tb.sv =====
// ----------------------------------------------------------------------------
// lidar_packet_deframe_and_bin_tb: regression bench for the packet deframer
// Feeds header-hunt noise and scanner packets with assorted angle spans and
// distances under random stalls on both sides, across several thresholds.
// ----------------------------------------------------------------------------
module lidar_packet_deframe_and_bin_tb;
    import ldpb_pkg::*;

    localparam int          HALF_PERIOD    = 6;
    localparam int          RESET_CYCLES   = 6;
    localparam int          IDLE_PCT       = 28;
    localparam int          ITEM_TARGET    = 220;
    localparam int          MIN_FRAMES     = 6;
    localparam int          PHASES         = 5;
    localparam int          SETTLE_CYCLES  = 32;
    localparam int          DRAIN_CYCLES   = 240;
    localparam int          TIMEOUT_CYCLES = 400000;
    localparam logic [15:0] MIN_DIST_RESET = 16'd150;

    // Angle patterns for the start/end fields of a packet
    typedef enum int {
        ANG_SWEEP,      // ordinary span inside the circle
        ANG_WRAP,       // end below start, span crosses zero
        ANG_FOLD,       // near zero, mirrored bin rounds up to 360 and folds to 0
        ANG_WILD,       // raw 16-bit values, far beyond 360 degrees
        ANG_EXTREME,    // all zeros / all ones
        ANG_FLAT,       // start equals end
        ANG_KINDS
    } t_angle_kind;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        s_tvalid    = 1'b0;
    logic [7:0]  s_tdata     = '0;
    logic        m_tready    = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [39:0] m_tdata;
    wire  [1:0]  m_tuser;
    wire         m_tlast;

    int          fail_count;
    int          points_pending;
    bit          src_steady   = 1'b0;
    bit          sink_steady  = 1'b0;
    int          bytes_sent   = 0;
    int          frames_sent  = 0;
    logic [15:0] cur_min_dist = MIN_DIST_RESET;

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    lidar_packet_deframe_and_bin u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    ldpb_point_checker u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (s_tvalid),
        .i_in_ready       (s_tready),
        .i_in_byte        (s_tdata),
        .i_pt_valid       (m_tvalid),
        .i_pt_ready       (m_tready),
        .i_pt_data        (m_tdata),
        .i_pt_user        (m_tuser),
        .i_pt_last        (m_tlast),
        .o_fail_count     (fail_count),
        .o_points_pending (points_pending)
    );

    // Sink: stall at random unless a steady stretch is running
    always @(negedge i_clk) begin
        m_tready <= sink_steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Offer one byte, idling first at random; return at the falling edge after
    // the transfer with tvalid still high so back-to-back bytes need no gap.
    task automatic send_byte(input logic [7:0] b);
        while (!src_steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    initial begin
        logic [7:0]  frame [PACKET_BYTES];
        logic [15:0] start_ang;
        logic [15:0] stop_ang;
        logic [15:0] range_mm;
        t_angle_kind kind;
        int          len;
        int          frames_in_phase;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Header hunt: plain noise, a lone second header byte, a first header
        // byte followed by junk, then a repeated first header byte that the
        // next packet's header continues.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(HDR1);
        send_byte(HDR0);
        send_byte(8'hAA);
        send_byte(HDR0);
        send_byte(HDR0);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                // Hold the source until every point is out, then move the threshold
                s_tvalid <= 1'b0;
                while (points_pending != 0) @(negedge i_clk);
                repeat (SETTLE_CYCLES) @(negedge i_clk);
                case (ph)
                    1:       cur_min_dist = 16'h0000;
                    2:       cur_min_dist = 16'hFFFF;
                    3:       cur_min_dist = 16'($urandom_range(1, 65534));
                    default: cur_min_dist = MIN_DIST_RESET;
                endcase
                i_cfg_we    <= 1'b1;
                i_cfg_wdata <= cur_min_dist;
                @(negedge i_clk);
                i_cfg_we    <= 1'b0;
            end

            // One phase runs with no idling on either side
            src_steady  = (ph == 2);
            sink_steady = (ph == 2);
            frames_in_phase = 0;

            do begin
                // Walk every angle pattern once in order, then pick at random
                if (frames_sent < ANG_KINDS) begin
                    kind = t_angle_kind'(frames_sent);
                end else begin
                    kind = t_angle_kind'($urandom_range(0, ANG_KINDS - 1));
                end
                case (kind)
                    ANG_SWEEP: begin
                        start_ang = 16'($urandom_range(0, CIRCLE - 1));
                        stop_ang  = 16'((start_ang + $urandom_range(0, 3000)) % CIRCLE);
                    end
                    ANG_WRAP: begin
                        start_ang = 16'($urandom_range(CIRCLE - 1000, CIRCLE - 1));
                        stop_ang  = 16'($urandom_range(0, 999));
                    end
                    ANG_FOLD: begin
                        start_ang = 16'($urandom_range(1, 50));
                        stop_ang  = start_ang + 16'($urandom_range(0, 600));
                    end
                    ANG_WILD: begin
                        start_ang = 16'($urandom);
                        stop_ang  = 16'($urandom);
                    end
                    ANG_EXTREME: begin
                        start_ang = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                        stop_ang  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    end
                    default: begin
                        start_ang = 16'($urandom);
                        stop_ang  = start_ang;
                    end
                endcase

                frame[0]        = HDR0;
                frame[1]        = HDR1;
                frame[2]        = 8'($urandom);
                frame[3]        = 8'($urandom);
                frame[START_LO] = start_ang[7:0];
                frame[START_HI] = start_ang[15:8];
                for (int i = 0; i < POINTS; i++) begin
                    // Distances cluster around the threshold to probe the strict compare
                    case ($urandom_range(0, 5))
                        0:       range_mm = 16'h0000;
                        1:       range_mm = 16'hFFFF;
                        2:       range_mm = cur_min_dist;
                        3:       range_mm = cur_min_dist + 16'd1;
                        4:       range_mm = cur_min_dist - 16'd1;
                        default: range_mm = 16'($urandom);
                    endcase
                    frame[PT_FIRST + 3 * i]     = range_mm[7:0];
                    frame[PT_FIRST + 3 * i + 1] = range_mm[15:8];
                    frame[PT_FIRST + 3 * i + 2] = 8'($urandom);
                end
                frame[END_LO] = stop_ang[7:0];
                frame[END_HI] = stop_ang[15:8];
                // timestamp and CRC: arbitrary, the CRC is never checked
                for (int i = END_HI + 1; i < PACKET_BYTES; i++) begin
                    frame[i] = 8'($urandom);
                end

                // Once the patterns are covered, cut some packets short so the
                // next header lands inside a packet body.
                len = PACKET_BYTES;
                if (frames_sent >= ANG_KINDS && $urandom_range(0, 99) < 10) begin
                    len = $urandom_range(3, PACKET_BYTES - 1);
                end

                // Line noise between packets
                if ($urandom_range(0, 99) < 25) begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
                end

                for (int i = 0; i < len; i++) begin
                    send_byte(frame[i]);
                end
                if (len == PACKET_BYTES) begin
                    frames_sent++;
                end
                frames_in_phase++;
            end while ((ph == 2 && frames_in_phase < 2) ||
                       (ph == PHASES - 1 &&
                        (bytes_sent < ITEM_TARGET || frames_sent < MIN_FRAMES)));
        end

        // Drop the source, drain the points, then watch for strays
        s_tvalid    <= 1'b0;
        src_steady  = 1'b0;
        sink_steady = 1'b0;
        while (points_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && points_pending == 0) begin
            $display("lidar_packet_deframe_and_bin regression: pass");
        end else begin
            $display("lidar_packet_deframe_and_bin regression: fail");
        end
        $finish;
    end

    // Watchdog for a hung handshake
    initial begin
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("lidar_packet_deframe_and_bin regression: fail");
        $finish;
    end

endmodule
